FILE: hw/rtl/icmpbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icmpbl_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned EXPIRY_W = 31;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned PROTO_W  = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 31'd60000;

    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] LOOPBACK_MASK  = 32'hFF00_0000;
    localparam logic [ADDR_W-1:0] LOOPBACK_NET   = 32'h7F00_0000;

    // operation broadcast to every cell for the item in flight
    typedef struct packed {
        logic              check;
        logic              add;
        logic              clear;
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] now;
    } cell_op_t;

    // token and running results handed from cell to cell
    typedef struct packed {
        logic vld;
        logic any_live;
        logic hit;
        logic placed;
    } carry_t;

    function automatic logic address_ok(input logic [ADDR_W-1:0] a);
        address_ok = (a != '0) && (a != ADDR_ALL_ONES)
                     && ((a & LOOPBACK_MASK) != LOOPBACK_NET);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/icmp_source_blocklist_with_aging_core.sv
// An input transfer launches a token that walks the chain of table cells one cell
//   per cycle; its result is registered as it leaves the last cell and then loaded
//   into the output register, and no new input is accepted until that load is done
// reset: synchronous active-low aresetn empties the table, zeroes the tick
//   counter, puts the filter in standby and loads expiry_reg with 60000
`timescale 1ns / 1ps
`default_nettype none

module icmp_source_blocklist_with_aging_core
    import icmpbl_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [39:0]         s_tdata,   // protocol[7:0], address[39:8]
    input  wire logic [1:0]          s_tuser,   // command[1:0]

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // verdict[0], status[2:1], zero[7:3]

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [EXPIRY_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    cell_op_t            op_reg;
    logic                start_reg;
    logic                is_add_reg, add_bad_reg, is_tick_reg;
    logic [TIME_W-1:0]   time_reg;
    logic                active_reg;
    logic [EXPIRY_W-1:0] expiry_reg;
    logic                res_verdict_reg;
    logic [STATUS_W-1:0] res_status_reg, status_next;
    logic                m_tvalid_reg;
    logic [7:0]          m_tdata_reg;

    carry_t              chain [TABLE_ENTRIES+1];

    logic                in_xfer;
    logic                done;
    logic                out_load;
    logic [CMD_W-1:0]    cmd_in;
    logic [PROTO_W-1:0]  proto_in;
    logic [ADDR_W-1:0]   addr_in;

    assign cmd_in   = s_tuser;
    assign proto_in = s_tdata[7:0];
    assign addr_in  = s_tdata[39:8];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign done      = chain[TABLE_ENTRIES].vld;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign chain[0] = '{vld: start_reg, any_live: 1'b0, hit: 1'b0, placed: 1'b0};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        icmpbl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (op_reg),
            .expiry    (expiry_reg),
            .carry_in  (chain[g]),
            .carry_out (chain[g+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_RUN;
            S_RUN:  if (done) state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        status_next = ST_OK;
        if (is_add_reg) begin
            if (add_bad_reg) begin
                status_next = ST_INVALID;
            end else if (!chain[TABLE_ENTRIES].placed) begin
                status_next = ST_FULL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            time_reg     <= '0;
            active_reg   <= 1'b0;
            expiry_reg   <= EXPIRY_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= in_xfer;
            if (cfg_valid && cfg_ready) begin
                expiry_reg <= cfg_data;
            end
            if (done) begin
                if (is_tick_reg) begin
                    time_reg <= time_reg + 1'b1;
                end
                if (op_reg.check && !chain[TABLE_ENTRIES].any_live) begin
                    active_reg <= 1'b0;
                end else if (op_reg.add && chain[TABLE_ENTRIES].placed) begin
                    active_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg.check   <= (cmd_in == CMD_PACKET) && active_reg && (proto_in == PROTO_ICMP);
            op_reg.add     <= (cmd_in == CMD_ADD) && address_ok(addr_in);
            op_reg.clear   <= (cmd_in == CMD_CLEAR);
            op_reg.address <= addr_in;
            op_reg.now     <= time_reg;
            is_add_reg     <= (cmd_in == CMD_ADD);
            add_bad_reg    <= !address_ok(addr_in);
            is_tick_reg    <= (cmd_in == CMD_TICK);
        end
        if (done) begin
            res_verdict_reg <= chain[TABLE_ENTRIES].hit;
            res_status_reg  <= status_next;
        end
        if (out_load) begin
            m_tdata_reg <= {5'b0, res_status_reg, res_verdict_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == S_RUN))
        else $error("chain token left the last cell outside of run");

    a_start_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> start_reg && (state_reg == S_RUN))
        else $error("input transfer did not launch a token");

    a_verdict_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[2:1] != ST_OK)))
        else $error("drop verdict together with a nonzero status");

    a_add_activates: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && op_reg.add && chain[TABLE_ENTRIES].placed) |=> active_reg)
        else $error("successful add left the filter in standby");

endmodule

`default_nettype wire

FILE: hw/rtl/icmpbl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module icmpbl_cell
    import icmpbl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cell_op_t            op,
    input  wire logic [EXPIRY_W-1:0] expiry,
    input  wire carry_t              carry_in,
    output carry_t                   carry_out
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] stamp_reg;
    carry_t            carry_reg, carry_next;
    logic [TIME_W-1:0] age;
    logic              live;
    logic              take;

    assign age  = op.now - stamp_reg;
    assign live = valid_reg && (age <= {1'b0, expiry});
    assign take = carry_in.vld && op.add && !carry_in.placed && !live;

    always_comb begin
        carry_next.vld      = carry_in.vld;
        carry_next.any_live = carry_in.any_live | (op.check & live);
        carry_next.hit      = carry_in.hit | (op.check & live & (addr_reg == op.address));
        carry_next.placed   = carry_in.placed | (op.add & !live);

        valid_next = valid_reg;
        if (carry_in.vld) begin
            if (op.clear) begin
                valid_next = 1'b0;
            end else if (op.check && valid_reg && !live) begin
                valid_next = 1'b0;
            end else if (take) begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            addr_reg  <= op.address;
            stamp_reg <= op.now;
        end
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire
